// ===== design/sp_pkg.sv =====
// shared constants, codes and types for the shortest path block
`timescale 1ns / 1ps
package sp_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int EDGE_AW   = 2 * NODE_W;
    localparam int DIST_W    = 22;
    localparam int WEIGHT_W  = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_MIRROR,
        ST_RUN_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

    typedef struct packed {
        logic                present;
        logic [WEIGHT_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic                en;
        logic [EDGE_AW-1:0]  addr;
        logic [WEIGHT_W-1:0] weight;
    } t_edge_wr;

    typedef struct packed {
        logic [DIST_W-1:0] path_len;
        logic [NODE_W-1:0] parent;
    } t_node;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        t_node             data;
    } t_node_wr;

endpackage

// ===== design/sp_if.sv =====
// handshake channels: command items, result items, register writes
`timescale 1ns / 1ps
interface sp_in_if;
    logic                               valid;
    logic                               ready;
    logic [sp_pkg::OP_W-1:0]            opcode;
    logic [sp_pkg::NODE_W-1:0]          src_node;
    logic [sp_pkg::NODE_W-1:0]          dst_node;
    logic [sp_pkg::WEIGHT_W-1:0]        edge_weight;

    modport source (output valid, opcode, src_node, dst_node, edge_weight, input ready);
    modport sink   (input valid, opcode, src_node, dst_node, edge_weight, output ready);
endinterface

interface sp_out_if;
    logic                               valid;
    logic                               ready;
    logic [sp_pkg::NODE_W-1:0]          node_index;
    logic [sp_pkg::DIST_W-1:0]          distance;
    logic                               reachable;
    logic [sp_pkg::NODE_W-1:0]          predecessor;
    logic                               has_predecessor;
    logic                               last;

    modport source (output valid, node_index, distance, reachable, predecessor,
                    has_predecessor, last, input ready);
    modport sink   (input valid, node_index, distance, reachable, predecessor,
                    has_predecessor, last, output ready);
endinterface

interface sp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sp_pkg::CFG_IDX_W-1:0]       reg_index;
    logic [sp_pkg::CFG_DAT_W-1:0]       wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== design/sp_alu.sv =====
// shared add and compare unit used by the min scan and the relax pass
`timescale 1ns / 1ps
module sp_alu (
    input  logic [sp_pkg::DIST_W-1:0]   i_base,
    input  logic [sp_pkg::WEIGHT_W-1:0] i_add,
    input  logic [sp_pkg::DIST_W-1:0]   i_ref,
    output logic [sp_pkg::DIST_W-1:0]   o_sum,
    output logic                        o_less
);

    logic [sp_pkg::DIST_W:0] sum_full;

    // distances stay below 2^22, the carry is only kept for the width match
    assign sum_full = {1'b0, i_base} + {{(sp_pkg::DIST_W + 1 - sp_pkg::WEIGHT_W){1'b0}}, i_add};
    assign o_sum    = sum_full[sp_pkg::DIST_W-1:0];
    assign o_less   = sum_full < {1'b0, i_ref};

endmodule

// ===== design/sp_edge_mem.sv =====
// adjacency matrix memory with a clearing sweep after reset and on request
`timescale 1ns / 1ps
module sp_edge_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  sp_pkg::t_edge_wr             i_wr,
    input  logic [sp_pkg::EDGE_AW-1:0]   i_raddr,
    output sp_pkg::t_edge                o_rdata,
    output logic                         o_busy
);

    sp_pkg::t_edge               mem [2**sp_pkg::EDGE_AW];
    logic                        r_clr_busy;
    logic [sp_pkg::EDGE_AW-1:0]  r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + sp_pkg::EDGE_AW'(1);
            if (r_clr_addr == {sp_pkg::EDGE_AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end else if (i_clear) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            mem[i_wr.addr] <= '{present: 1'b1, weight: i_wr.weight};
        end
        o_rdata <= mem[i_raddr];
    end

    assign o_busy = r_clr_busy;

endmodule

// ===== design/sp_node_mem.sv =====
// per node distance and parent memory, one write and one registered read
`timescale 1ns / 1ps
module sp_node_mem (
    input  logic                        i_clk,
    input  sp_pkg::t_node_wr            i_wr,
    input  logic [sp_pkg::NODE_W-1:0]   i_raddr,
    output sp_pkg::t_node               o_rdata
);

    sp_pkg::t_node mem [sp_pkg::MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== design/shortest_paths_dijkstra.sv =====
// top level: command decode, run sequencer and result output register
//
//  channel | dir | payload                                         | accepted when
//  i_cmd   | in  | opcode, src_node, dst_node, edge_weight         | valid & ready
//  o_res   | out | node_index, distance, reachable, predecessor,   | valid & ready
//          |     | has_predecessor, last                           |
//  i_cfg   | in  | reg_index, wr_data                              | valid & ready (always ready)
//
// add edge writes one matrix entry, and its mirror too when undirected; clear sweeps the whole matrix
// a run of n nodes: an init step, then per settled node a min scan and a relax pass over
// all n nodes through the single read port of the distance memory, one final scan,
// and a read step and a load step per result
// after reset the matrix clearing sweep holds i_cmd.ready low until it has cleared every entry
// a stalled result holds the sequencer; the last result can wait while the next item enters
`timescale 1ns / 1ps
module shortest_paths_dijkstra (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sp_in_if.sink     i_cmd,
    sp_out_if.source  o_res,
    sp_cfg_if.sink    i_cfg
);

    localparam int NW = sp_pkg::NODE_W;
    localparam int CW = sp_pkg::CNT_W;

    sp_pkg::t_state              r_state, n_state;

    logic [sp_pkg::CFG_DAT_W-1:0] r_node_count;
    logic [NW-1:0]               r_start;
    logic                        r_directed;

    logic [CW-1:0]               r_cnt;
    logic                        r_pv;
    logic [NW-1:0]               r_pidx;
    logic [sp_pkg::MAX_NODES-1:0] r_reached, r_settled, r_has_par;
    logic                        r_found;
    logic [sp_pkg::DIST_W-1:0]   r_best;
    logic [NW-1:0]               r_u;

    logic [NW-1:0]               r_mir_src, r_mir_dst;
    logic [sp_pkg::WEIGHT_W-1:0] r_mir_w;

    logic                        r_ovalid;
    logic [NW-1:0]               r_o_idx;
    logic [sp_pkg::DIST_W-1:0]   r_o_dist;
    logic                        r_o_reach;
    logic [NW-1:0]               r_o_pred;
    logic                        r_o_haspred;
    logic                        r_o_last;

    logic [CW-1:0]               n_nodes;
    logic                        start_ok;
    logic                        accept;
    logic                        clr_busy;
    logic                        clear_start;
    logic                        issue;
    logic                        pass_done;
    logic                        pick;
    logic                        upd;
    logic                        out_load;
    logic                        out_last;
    logic                        node_ok;

    sp_pkg::t_edge_wr            edge_wr;
    logic [sp_pkg::EDGE_AW-1:0]  edge_raddr;
    sp_pkg::t_edge               edge_q;
    sp_pkg::t_node_wr            node_wr;
    logic [NW-1:0]               node_raddr;
    sp_pkg::t_node               node_q;

    logic [sp_pkg::DIST_W-1:0]   alu_base, alu_ref, alu_sum;
    logic [sp_pkg::WEIGHT_W-1:0] alu_add;
    logic                        alu_less;

    sp_edge_mem u_edge_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clear_start),
        .i_wr    (edge_wr),
        .i_raddr (edge_raddr),
        .o_rdata (edge_q),
        .o_busy  (clr_busy)
    );

    sp_node_mem u_node_mem (
        .i_clk   (i_clk),
        .i_wr    (node_wr),
        .i_raddr (node_raddr),
        .o_rdata (node_q)
    );

    sp_alu u_alu (
        .i_base (alu_base),
        .i_add  (alu_add),
        .i_ref  (alu_ref),
        .o_sum  (alu_sum),
        .o_less (alu_less)
    );

    // node count clamped to 1..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            n_nodes = CW'(1);
        end else if (r_node_count > sp_pkg::CFG_DAT_W'(sp_pkg::MAX_NODES)) begin
            n_nodes = CW'(sp_pkg::MAX_NODES);
        end else begin
            n_nodes = CW'(r_node_count);
        end
    end

    assign start_ok    = {1'b0, r_start} < n_nodes;
    assign i_cmd.ready = (r_state == sp_pkg::ST_IDLE) && !clr_busy;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign clear_start = accept && (i_cmd.opcode == sp_pkg::OP_CLEAR);
    assign i_cfg.ready = 1'b1;

    assign issue     = r_cnt < n_nodes;
    assign pass_done = !issue && !r_pv;
    assign node_ok   = r_reached[r_pidx];
    assign pick      = r_pv && node_ok && !r_settled[r_pidx] && (!r_found || alu_less);
    assign upd       = r_pv && edge_q.present && (!node_ok || alu_less);
    assign out_load  = !r_ovalid || o_res.ready;
    assign out_last  = (r_cnt + CW'(1)) == n_nodes;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sp_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.opcode)
                        sp_pkg::OP_ADD_EDGE: begin
                            if (!r_directed) begin
                                n_state = sp_pkg::ST_ADD_MIRROR;
                            end
                        end
                        sp_pkg::OP_RUN: n_state = sp_pkg::ST_RUN_INIT;
                        default: n_state = sp_pkg::ST_IDLE;
                    endcase
                end
            end
            sp_pkg::ST_ADD_MIRROR: n_state = sp_pkg::ST_IDLE;
            sp_pkg::ST_RUN_INIT: begin
                n_state = start_ok ? sp_pkg::ST_SCAN : sp_pkg::ST_OUT_RD;
            end
            sp_pkg::ST_SCAN: begin
                if (pass_done) begin
                    n_state = r_found ? sp_pkg::ST_RELAX : sp_pkg::ST_OUT_RD;
                end
            end
            sp_pkg::ST_RELAX: begin
                if (pass_done) begin
                    n_state = sp_pkg::ST_SCAN;
                end
            end
            sp_pkg::ST_OUT_RD: n_state = sp_pkg::ST_OUT_LD;
            sp_pkg::ST_OUT_LD: begin
                if (out_load) begin
                    n_state = out_last ? sp_pkg::ST_IDLE : sp_pkg::ST_OUT_RD;
                end
            end
            default: n_state = sp_pkg::ST_IDLE;
        endcase
    end

    // memory ports and shared unit operands
    always_comb begin
        edge_wr    = '0;
        node_wr    = '0;
        edge_raddr = {r_u, r_cnt[NW-1:0]};
        node_raddr = r_cnt[NW-1:0];
        alu_base   = node_q.path_len;
        alu_add    = '0;
        alu_ref    = r_best;
        unique case (r_state)
            sp_pkg::ST_IDLE: begin
                edge_wr.en     = accept && (i_cmd.opcode == sp_pkg::OP_ADD_EDGE);
                edge_wr.addr   = {i_cmd.src_node, i_cmd.dst_node};
                edge_wr.weight = i_cmd.edge_weight;
            end
            sp_pkg::ST_ADD_MIRROR: begin
                edge_wr.en     = 1'b1;
                edge_wr.addr   = {r_mir_dst, r_mir_src};
                edge_wr.weight = r_mir_w;
            end
            sp_pkg::ST_RUN_INIT: begin
                node_wr.en   = start_ok;
                node_wr.addr = r_start;
                node_wr.data = '0;
            end
            sp_pkg::ST_RELAX: begin
                // candidate = dist[u] + w, compared against dist[v]
                alu_base                = r_best;
                alu_add                 = edge_q.weight;
                alu_ref                 = node_q.path_len;
                node_wr.en              = upd;
                node_wr.addr            = r_pidx;
                node_wr.data.path_len   = alu_sum;
                node_wr.data.parent     = r_u;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sp_pkg::ST_IDLE;
            r_node_count <= sp_pkg::CFG_DAT_W'(sp_pkg::MAX_NODES);
            r_start      <= '0;
            r_directed   <= 1'b1;
            r_cnt        <= '0;
            r_pv         <= 1'b0;
            r_pidx       <= '0;
            r_reached    <= '0;
            r_settled    <= '0;
            r_has_par    <= '0;
            r_found      <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    sp_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg.wr_data;
                    sp_pkg::CFG_START_NODE: r_start      <= i_cfg.wr_data[NW-1:0];
                    sp_pkg::CFG_DIRECTED:   r_directed   <= i_cfg.wr_data[0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                sp_pkg::ST_RUN_INIT: begin
                    r_reached <= start_ok ? (sp_pkg::MAX_NODES'(1) << r_start) : '0;
                    r_settled <= '0;
                    r_has_par <= '0;
                    r_cnt     <= '0;
                    r_pv      <= 1'b0;
                    r_found   <= 1'b0;
                end
                sp_pkg::ST_SCAN: begin
                    r_cnt  <= pass_done ? '0 : r_cnt + CW'(issue);
                    r_pv   <= issue;
                    r_pidx <= r_cnt[NW-1:0];
                    if (pick) begin
                        r_found <= 1'b1;
                        r_best  <= node_q.path_len;
                        r_u     <= r_pidx;
                    end
                    if (pass_done && r_found) begin
                        r_settled[r_u] <= 1'b1;
                    end
                end
                sp_pkg::ST_RELAX: begin
                    r_cnt  <= pass_done ? '0 : r_cnt + CW'(issue);
                    r_pv   <= issue;
                    r_pidx <= r_cnt[NW-1:0];
                    if (upd) begin
                        r_reached[r_pidx] <= 1'b1;
                        r_has_par[r_pidx] <= 1'b1;
                    end
                    if (pass_done) begin
                        r_found <= 1'b0;
                    end
                end
                sp_pkg::ST_OUT_LD: begin
                    if (out_load && !out_last) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: begin
                end
            endcase

            if (r_state == sp_pkg::ST_OUT_LD && out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == sp_pkg::ST_IDLE && accept) begin
            r_mir_src <= i_cmd.src_node;
            r_mir_dst <= i_cmd.dst_node;
            r_mir_w   <= i_cmd.edge_weight;
        end
        if (r_state == sp_pkg::ST_OUT_LD && out_load) begin
            r_o_idx     <= r_cnt[NW-1:0];
            r_o_reach   <= r_reached[r_cnt[NW-1:0]];
            r_o_dist    <= r_reached[r_cnt[NW-1:0]] ? node_q.path_len : '0;
            r_o_haspred <= r_reached[r_cnt[NW-1:0]] && r_has_par[r_cnt[NW-1:0]];
            r_o_pred    <= (r_reached[r_cnt[NW-1:0]] && r_has_par[r_cnt[NW-1:0]]) ?
                           node_q.parent : '0;
            r_o_last    <= out_last;
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.node_index      = r_o_idx;
    assign o_res.distance        = r_o_dist;
    assign o_res.reachable       = r_o_reach;
    assign o_res.predecessor     = r_o_pred;
    assign o_res.has_predecessor = r_o_haspred;
    assign o_res.last            = r_o_last;

    // a settled node was always reached first
    a_settled_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settled & ~r_reached) == '0)
        else $error("settled node not reached");

    // a predecessor only exists for a reached node
    a_parent_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_has_par & ~r_reached) == '0)
        else $error("predecessor on unreached node");

    // the node chosen by the scan is reached and still open
    a_pick_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sp_pkg::ST_SCAN && n_state == sp_pkg::ST_RELAX)
            |-> (r_reached[r_u] && !r_settled[r_u]))
        else $error("scan chose a settled or unreached node");

    // the relaxing node is settled for the whole pass
    a_relax_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sp_pkg::ST_RELAX |-> r_settled[r_u])
        else $error("relax pass on an unsettled node");

endmodule

// ===== tb/tb_shortest_paths_dijkstra.sv =====
// self-checking testbench for the shortest path block with its own path predictor
`timescale 1ns / 1ps
module tb_shortest_paths_dijkstra;

    localparam int          RESET_CYCLES = 7;
    localparam int          QUIET_CYCLES = 4200;   // covers a full matrix clearing sweep
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          RANDOM_ITEMS = 44;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      TIMEOUT_NS   = 64'd50_000_000;

    localparam logic [sp_pkg::OP_W-1:0]      OP_IGNORED     = 2'd3;
    localparam logic [sp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic [sp_pkg::NODE_W-1:0] node_index;
        logic [sp_pkg::DIST_W-1:0] distance;
        logic                      reachable;
        logic [sp_pkg::NODE_W-1:0] predecessor;
        logic                      has_predecessor;
        logic                      last;
    } t_node_report;

    logic i_clk;
    logic i_rst_n;

    sp_in_if  cmd_ch ();
    sp_out_if res_ch ();
    sp_cfg_if cfg_ch ();

    shortest_paths_dijkstra dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state
    sp_pkg::t_edge             edge_mem [sp_pkg::MAX_NODES][sp_pkg::MAX_NODES];
    logic [sp_pkg::CNT_W-1:0]  cfg_nodes;
    logic [sp_pkg::NODE_W-1:0] cfg_start;
    logic                      cfg_directed;
    t_node_report              expected_reports [$];

    int unsigned snd_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned error_count;
    logic        rx_hold;
    event        hold_kick;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side ready, random stalls or a long hold-off
    always @(posedge i_clk) begin
        if (rx_hold) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        rx_hold <= 1'b0;
        forever begin
            @(hold_kick);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_node_report got;
        t_node_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.node_index, res_ch.distance, res_ch.reachable,
                    res_ch.predecessor, res_ch.has_predecessor, res_ch.last};
            if (expected_reports.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: node %0d dist %0d reach %0b pred %0d",
                             got.node_index, got.distance, got.reachable, got.predecessor);
            end else begin
                want = expected_reports.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"result mismatch: exp node %0d dist %0d reach %0b",
                                  " pred %0d hp %0b last %0b"},
                                 want.node_index, want.distance, want.reachable,
                                 want.predecessor, want.has_predecessor, want.last);
                        $display({"                 got node %0d dist %0d reach %0b",
                                  " pred %0d hp %0b last %0b"},
                                 got.node_index, got.distance, got.reachable,
                                 got.predecessor, got.has_predecessor, got.last);
                    end
                end
            end
        end
    end

    function automatic void wipe_edges();
        for (int r = 0; r < sp_pkg::MAX_NODES; r++)
            for (int c = 0; c < sp_pkg::MAX_NODES; c++)
                edge_mem[r][c] = '0;
    endfunction

    // closest unsettled node first, lowest index on ties, strict improvement only
    function automatic void solve_paths();
        int unsigned               n;
        int unsigned               u;
        int unsigned               v;
        int unsigned               step;
        bit                        found;
        bit                        more;
        logic [31:0]               cand;
        logic [31:0]               cost    [sp_pkg::MAX_NODES];
        logic [sp_pkg::NODE_W-1:0] parent  [sp_pkg::MAX_NODES];
        bit                        reached [sp_pkg::MAX_NODES];
        bit                        settled [sp_pkg::MAX_NODES];
        bit                        linked  [sp_pkg::MAX_NODES];
        t_node_report              rep;
        n = cfg_nodes;
        if (n < 1) n = 1;
        if (n > sp_pkg::MAX_NODES) n = sp_pkg::MAX_NODES;
        for (v = 0; v < sp_pkg::MAX_NODES; v++) begin
            cost[v]    = '0;
            parent[v]  = '0;
            reached[v] = 1'b0;
            settled[v] = 1'b0;
            linked[v]  = 1'b0;
        end
        if (cfg_start < n) begin
            reached[cfg_start] = 1'b1;
            more = 1'b1;
            for (step = 0; step < n && more; step++) begin
                found = 1'b0;
                u = 0;
                for (v = 0; v < n; v++) begin
                    if (reached[v] && !settled[v] && (!found || cost[v] < cost[u])) begin
                        u = v;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    more = 1'b0;
                end else begin
                    settled[u] = 1'b1;
                    for (v = 0; v < n; v++) begin
                        if (edge_mem[u][v].present) begin
                            cand = cost[u] + edge_mem[u][v].weight;
                            if (!reached[v] || cand < cost[v]) begin
                                reached[v] = 1'b1;
                                cost[v]    = cand;
                                parent[v]  = sp_pkg::NODE_W'(u);
                                linked[v]  = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        for (v = 0; v < n; v++) begin
            rep.node_index      = sp_pkg::NODE_W'(v);
            rep.distance        = reached[v] ? cost[v][sp_pkg::DIST_W-1:0] : '0;
            rep.reachable       = reached[v];
            rep.predecessor     = (reached[v] && linked[v]) ? parent[v] : '0;
            rep.has_predecessor = reached[v] && linked[v];
            rep.last            = (v + 1 == n);
            expected_reports.push_back(rep);
        end
    endfunction

    task automatic send_cmd(input logic [sp_pkg::OP_W-1:0] op,
                            input logic [sp_pkg::NODE_W-1:0] src,
                            input logic [sp_pkg::NODE_W-1:0] dst,
                            input logic [sp_pkg::WEIGHT_W-1:0] w);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.src_node    <= src;
        cmd_ch.dst_node    <= dst;
        cmd_ch.edge_weight <= w;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        case (op)
            sp_pkg::OP_ADD_EDGE: begin
                edge_mem[src][dst] = '{present: 1'b1, weight: w};
                if (!cfg_directed)
                    edge_mem[dst][src] = '{present: 1'b1, weight: w};
            end
            sp_pkg::OP_CLEAR: wipe_edges();
            sp_pkg::OP_RUN:   solve_paths();
            default: ;
        endcase
    endtask

    task automatic add_edge(input logic [sp_pkg::NODE_W-1:0] src,
                            input logic [sp_pkg::NODE_W-1:0] dst,
                            input logic [sp_pkg::WEIGHT_W-1:0] w);
        send_cmd(sp_pkg::OP_ADD_EDGE, src, dst, w);
    endtask

    task automatic start_run();
        send_cmd(sp_pkg::OP_RUN, sp_pkg::NODE_W'($urandom), sp_pkg::NODE_W'($urandom),
                 sp_pkg::WEIGHT_W'($urandom));
    endtask

    task automatic clear_matrix();
        send_cmd(sp_pkg::OP_CLEAR, sp_pkg::NODE_W'($urandom), sp_pkg::NODE_W'($urandom),
                 sp_pkg::WEIGHT_W'($urandom));
    endtask

    task automatic write_reg(input logic [sp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sp_pkg::CFG_DAT_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            sp_pkg::CFG_NODE_COUNT: cfg_nodes    = data;
            sp_pkg::CFG_START_NODE: cfg_start    = data[sp_pkg::NODE_W-1:0];
            sp_pkg::CFG_DIRECTED:   cfg_directed = data[0];
            default: ;
        endcase
    endtask

    // registers change only once the block has drained and gone quiet
    task automatic set_config(input logic [sp_pkg::CNT_W-1:0] nodes,
                              input logic [sp_pkg::NODE_W-1:0] start,
                              input logic dir);
        cmd_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        write_reg(sp_pkg::CFG_NODE_COUNT, nodes);
        write_reg(sp_pkg::CFG_START_NODE, {1'($urandom_range(0, 1)), start});
        write_reg(sp_pkg::CFG_DIRECTED, {6'($urandom), dir});
        write_reg(CFG_IDX_UNUSED, sp_pkg::CFG_DAT_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // empty matrix with reset registers: only node 0 reachable among all 64
    task automatic test_reset_defaults();
        start_run();
    endtask

    task automatic test_basic_graph();
        set_config(7'd6, 6'd0, 1'b1);
        add_edge(6'd0, 6'd1, 16'd4);
        add_edge(6'd0, 6'd2, 16'd2);
        add_edge(6'd2, 6'd1, 16'd2);       // equal length, keeps the first parent
        add_edge(6'd1, 6'd3, 16'hFFFF);
        add_edge(6'd2, 6'd3, 16'd2);       // ties nodes 1 and 3 at distance 4
        add_edge(6'd3, 6'd3, 16'd0);       // self loop
        add_edge(6'd4, 6'd5, 16'd1);       // island off the start node
        add_edge(6'd0, 6'd63, 16'd0);      // beyond the node count, kept for later
        send_cmd(OP_IGNORED, sp_pkg::NODE_W'($urandom), sp_pkg::NODE_W'($urandom),
                 sp_pkg::WEIGHT_W'($urandom));
        start_run();
    endtask

    task automatic test_undirected_mirror();
        set_config(7'd6, 6'd5, 1'b0);
        add_edge(6'd4, 6'd5, 16'd7);
        add_edge(6'd3, 6'd4, 16'hFFFF);
        start_run();
    endtask

    task automatic test_start_out_of_range();
        set_config(7'd6, 6'd6, 1'b1);
        start_run();
    endtask

    task automatic test_node_count_limits();
        set_config(7'd0, 6'd0, 1'b1);
        start_run();
        set_config(7'd127, 6'd0, 1'b1);
        start_run();
    endtask

    task automatic test_clear_matrix();
        set_config(7'd2, 6'd0, 1'b1);
        clear_matrix();
        start_run();
    endtask

    // longest possible distance: 63 hops of maximum weight
    task automatic test_long_chain();
        set_config(7'd64, 6'd0, 1'b1);
        for (int k = 0; k < sp_pkg::MAX_NODES - 1; k++)
            add_edge(sp_pkg::NODE_W'(k), sp_pkg::NODE_W'(k + 1), 16'hFFFF);
        start_run();
    endtask

    task automatic test_backpressure();
        set_config(7'd16, 6'd0, 1'b1);
        repeat (8)
            add_edge(sp_pkg::NODE_W'($urandom_range(0, 15)),
                     sp_pkg::NODE_W'($urandom_range(0, 15)),
                     sp_pkg::WEIGHT_W'($urandom_range(0, 300)));
        -> hold_kick;
        start_run();
        add_edge(sp_pkg::NODE_W'($urandom_range(0, 15)),
                 sp_pkg::NODE_W'($urandom_range(0, 15)), 16'd9);
        start_run();
        start_run();
        add_edge(sp_pkg::NODE_W'($urandom_range(0, 15)),
                 sp_pkg::NODE_W'($urandom_range(0, 15)), 16'd1);
        start_run();
    endtask

    task automatic test_random_traffic();
        int unsigned                 counted;
        int unsigned                 n_eff;
        int unsigned                 n_adds;
        int unsigned                 k;
        logic [sp_pkg::CNT_W-1:0]    nodes;
        logic [sp_pkg::NODE_W-1:0]   start;
        logic [sp_pkg::NODE_W-1:0]   src;
        logic [sp_pkg::NODE_W-1:0]   dst;
        logic [sp_pkg::WEIGHT_W-1:0] w;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted < RANDOM_ITEMS / 3) begin
                snd_idle_pct = 23;
                rx_idle_pct  = 45;
            end else if (counted < 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = 45;
                rx_idle_pct  = 23;
            end else begin
                snd_idle_pct = 0;
                rx_idle_pct  = 0;
            end
            case ($urandom_range(0, 19))
                0:       nodes = 7'd0;
                1:       nodes = 7'd1;
                2:       nodes = 7'd64;
                3:       nodes = sp_pkg::CNT_W'($urandom_range(65, 127));
                default: nodes = sp_pkg::CNT_W'($urandom_range(2, 12));
            endcase
            n_eff = (nodes == 0) ? 1 :
                    ((nodes > sp_pkg::MAX_NODES) ? sp_pkg::MAX_NODES : nodes);
            if ($urandom_range(0, 7) == 0)
                start = sp_pkg::NODE_W'($urandom_range(0, 63));
            else
                start = sp_pkg::NODE_W'($urandom_range(0, n_eff - 1));
            set_config(nodes, start, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                clear_matrix();
                counted++;
            end
            repeat ($urandom_range(1, 3)) begin
                n_adds = $urandom_range(0, (n_eff > 12) ? 8 : 5);
                repeat (n_adds) begin
                    k = $urandom_range(0, 9);
                    if (k == 0) begin
                        send_cmd(OP_IGNORED, sp_pkg::NODE_W'($urandom),
                                 sp_pkg::NODE_W'($urandom), sp_pkg::WEIGHT_W'($urandom));
                    end else begin
                        if (k == 1) begin
                            src = sp_pkg::NODE_W'($urandom);
                            dst = sp_pkg::NODE_W'($urandom);
                        end else begin
                            src = sp_pkg::NODE_W'($urandom_range(0, n_eff - 1));
                            dst = sp_pkg::NODE_W'($urandom_range(0, n_eff - 1));
                        end
                        case ($urandom_range(0, 3))
                            0:       w = sp_pkg::WEIGHT_W'($urandom_range(0, 15));
                            1:       w = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                            default: w = sp_pkg::WEIGHT_W'($urandom);
                        endcase
                        add_edge(src, dst, w);
                    end
                    counted++;
                end
                start_run();
                counted++;
            end
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= sp_pkg::OP_ADD_EDGE;
        cmd_ch.src_node    <= '0;
        cmd_ch.dst_node    <= '0;
        cmd_ch.edge_weight <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= sp_pkg::CFG_NODE_COUNT;
        cfg_ch.wr_data     <= '0;
        snd_idle_pct = 23;
        rx_idle_pct  = 45;
        error_count  = 0;
        wipe_edges();
        cfg_nodes    = 7'd64;
        cfg_start    = 6'd0;
        cfg_directed = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_basic_graph();
        test_undirected_mirror();
        test_start_out_of_range();
        test_node_count_limits();
        test_clear_matrix();
        test_long_chain();
        test_backpressure();
        test_random_traffic();

        cmd_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
